// File: hdl/hdqmt_pkg.sv
package hdqmt_pkg;

	localparam int TICK_W = 6;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 3;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam logic [IDX_W-1:0]  LAST_BIT = '1;

	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BREAK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BREAK_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 2'd3;

	localparam logic [TICK_W-1:0] RST_BREAK_TICKS = 6'd20;
	localparam logic [TICK_W-1:0] RST_ONE_LOW     = 6'd3;
	localparam logic [TICK_W-1:0] RST_ZERO_LOW    = 6'd13;
	localparam logic [TICK_W-1:0] RST_BIT_PERIOD  = 6'd20;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_BRK_WAIT = 3'd1,
		PH_BRK_LOW  = 3'd2,
		PH_BIT_WAIT = 3'd3,
		PH_BIT_SLOT = 3'd4
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] break_ticks;
		logic [TICK_W-1:0] one_low_ticks;
		logic [TICK_W-1:0] zero_low_ticks;
		logic [TICK_W-1:0] bit_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic pin;
		logic busy;
		logic done;
	} res_t;

endpackage

// File: hdl/hdqmt_core.sv
module hdqmt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [hdqmt_pkg::KIND_W-1:0]  kind,
	input  logic [hdqmt_pkg::BYTE_W-1:0]  byte_value,
	input  logic                          line_level,
	input  hdqmt_pkg::cfg_t               cfg,
	output hdqmt_pkg::res_t               res
);
	import hdqmt_pkg::*;

	phase_t              phase_q, phase_d;
	logic [TICK_W-1:0]   tick_q, tick_d, tick_inc, low_len;
	logic [BYTE_W-1:0]   shift_q, shift_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic                pin_q, pin_d;
	logic                done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			shift_q <= '0;
			idx_q   <= '0;
			pin_q   <= 1'b1;
		end else if (step_en) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			idx_q   <= idx_d;
			pin_q   <= pin_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		shift_d  = shift_q;
		idx_d    = idx_q;
		pin_d    = pin_q;
		done     = 1'b0;
		tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
		low_len  = shift_q[0] ? cfg.one_low_ticks : cfg.zero_low_ticks;
		unique case (phase_q)
			PH_IDLE: begin
				if (kind == KIND_BREAK) begin
					phase_d = PH_BRK_WAIT;
				end else if (kind == KIND_BYTE) begin
					shift_d = byte_value;
					idx_d   = '0;
					phase_d = PH_BIT_WAIT;
				end
			end
			PH_BRK_WAIT: begin
				if (line_level) begin
					pin_d   = 1'b0;
					tick_d  = '0;
					phase_d = PH_BRK_LOW;
				end
			end
			PH_BRK_LOW: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.break_ticks) begin
					pin_d   = 1'b1;
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
			end
			PH_BIT_WAIT: begin
				if (!line_level) begin
					pin_d   = 1'b0;
					tick_d  = '0;
					phase_d = PH_BIT_SLOT;
				end
			end
			PH_BIT_SLOT: begin
				tick_d = tick_inc;
				if (tick_inc >= low_len) begin
					pin_d = 1'b1;
					if (tick_inc >= cfg.bit_period_ticks) begin
						if (idx_q == LAST_BIT) begin
							idx_d   = '0;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							idx_d   = idx_q + 1'b1;
							shift_d = shift_q >> 1;
							phase_d = PH_BIT_WAIT;
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				pin_d   = 1'b1;
			end
		endcase
		res.pin  = pin_d;
		res.busy = (phase_d != PH_IDLE);
		res.done = done;
	end

endmodule

// File: hdl/hdq_master_transmitter.sv
// HDQ single-wire master transmitter. Each input transfer is one 10 us tick carrying an
// optional command (break or byte) and the sampled line level; each tick yields exactly
// one result transfer with the output pin level, busy and done. Commands arriving while
// busy are ignored. A tick is registered on input, stepped through the state machine and
// registered again on output. One tick is taken every clock while no result waits;
// the output register drains independently, so input stalls only when a result waits
// and the input stage is full. Write timing registers only while no tick is in flight.
module hdq_master_transmitter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [hdqmt_pkg::KIND_W-1:0]     kind,
	input  logic [hdqmt_pkg::BYTE_W-1:0]     byte_value,
	input  logic                             line_level,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             pin_out,
	output logic                             busy_res,
	output logic                             done_res,
	input  logic                             cfg_we,
	input  logic [hdqmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdqmt_pkg::TICK_W-1:0]     cfg_data
);
	import hdqmt_pkg::*;

	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                line_s1;
	logic                advance;
	logic                out_valid_q;
	res_t                res_q;
	res_t                res_next;
	cfg_t                cfg_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.break_ticks      <= RST_BREAK_TICKS;
			cfg_q.one_low_ticks    <= RST_ONE_LOW;
			cfg_q.zero_low_ticks   <= RST_ZERO_LOW;
			cfg_q.bit_period_ticks <= RST_BIT_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BREAK_TICKS: cfg_q.break_ticks      <= cfg_data;
				CFG_ONE_LOW:     cfg_q.one_low_ticks    <= cfg_data;
				CFG_ZERO_LOW:    cfg_q.zero_low_ticks   <= cfg_data;
				CFG_BIT_PERIOD:  cfg_q.bit_period_ticks <= cfg_data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			byte_s1 <= byte_value;
			line_s1 <= line_level;
		end
	end

	hdqmt_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.kind       (kind_s1),
		.byte_value (byte_s1),
		.line_level (line_s1),
		.cfg        (cfg_q),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_out   = res_q.pin;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;

`ifndef SYNTHESIS
	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> pin_out && !busy_res)
		else $error("done result with pin low or still busy");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && valid_s1)
		else $error("input stalled while output can drain");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> pin_out)
		else $error("pin driven low while idle");

	a_step_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("stepped tick produced no result");
`endif

endmodule
